// ===== hdl/aiog_pkg.sv =====
// ----------------------------------------------------------------------------
// aiog_pkg
// Shared constants and types for the arm interlock output gate.
// ----------------------------------------------------------------------------
package aiog_pkg;

  localparam int AGE_WIDTH_DEF = 16;
  localparam int CFG_WIDTH     = 16;
  localparam int CFG_ADDR_W    = 1;
  localparam int IN_DATA_W     = 8;
  localparam int OUT_DATA_W    = 8;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = CFG_WIDTH'(25);
  localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET  = CFG_WIDTH'(1500);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEBOUNCE = 1'b0,
    REG_TIMEOUT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SW_CHECKING = 2'd0,
    SW_SAFE     = 2'd1,
    SW_ARM      = 2'd2
  } sw_status_t;

endpackage

// ===== hdl/arm_interlock_output_gate.sv =====
// ----------------------------------------------------------------------------
// arm_interlock_output_gate
// Debounces the SAFE/ARM switch, grants arming only on a debounced SAFE-to-ARM
// transition after SAFE was seen, tracks packet age and gates preview and
// stage outputs. One request is one millisecond tick.
//
//   channel | direction | tdata fields (lsb first)
//   in_     | input     | switch_raw, link_up, packet_valid
//   out_    | output    | arm_authorized, preview_enable, stage_enable,
//           |           | switch_status[1:0]
//   cfg_    | input     | 0 debounce_ticks, 1 packet_timeout_ticks
//
// One request per clock sustained while the receiver keeps up. An accepted
// request waits in the input stage register until the result side is free.
// Reset clears the valid flags and the switch and packet state and loads
// the register defaults. A stalled result holds in the output register; the
// input stage holds while blocked and accepts again once the result moves on.
// ----------------------------------------------------------------------------
module arm_interlock_output_gate #(
  parameter int AGE_WIDTH = aiog_pkg::AGE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [aiog_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [aiog_pkg::CFG_WIDTH-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // switch_raw, link_up, packet_valid, zero fill
  input  logic [aiog_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // arm_authorized, preview_enable, stage_enable, switch_status[1:0], zero fill
  output logic [aiog_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import aiog_pkg::*;

  localparam int CMP_W = (AGE_WIDTH > CFG_WIDTH) ? AGE_WIDTH : CFG_WIDTH;

  logic [CFG_WIDTH-1:0] debounce_r, timeout_r;

  logic       s1_valid_r;
  logic       s1_raw_r, s1_link_r, s1_pkt_r;
  logic       advance;

  logic                 last_raw_r, stable_r, confirmed_r, safe_seen_r, auth_r;
  logic                 pkt_seen_r;
  logic [AGE_WIDTH-1:0] level_age_r, pkt_age_r;

  logic                 last_raw_nxt, stable_nxt, confirmed_nxt, safe_seen_nxt, auth_nxt;
  logic                 pkt_seen_nxt;
  logic [AGE_WIDTH-1:0] level_age_nxt, pkt_age_nxt;
  logic                 settled, fresh, preview;
  sw_status_t           status;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      timeout_r  <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEBOUNCE: debounce_r <= cfg_wdata;
        REG_TIMEOUT:  timeout_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_raw_r  <= in_tdata[0];
      s1_link_r <= in_tdata[1];
      s1_pkt_r  <= in_tdata[2];
    end
  end

  always_comb begin
    last_raw_nxt  = last_raw_r;
    stable_nxt    = stable_r;
    confirmed_nxt = confirmed_r;
    safe_seen_nxt = safe_seen_r;
    auth_nxt      = s1_raw_r ? auth_r : 1'b0;
    pkt_seen_nxt  = pkt_seen_r;
    pkt_age_nxt   = pkt_age_r;

    if (s1_raw_r != last_raw_r) begin
      last_raw_nxt  = s1_raw_r;
      level_age_nxt = '0;
    end else begin
      level_age_nxt = (&level_age_r) ? level_age_r : level_age_r + 1'b1;
    end

    settled = CMP_W'(level_age_nxt) >= CMP_W'(debounce_r);
    if (settled && (!confirmed_r || stable_r != last_raw_nxt)) begin
      stable_nxt = last_raw_nxt;
      if (!confirmed_r) begin
        confirmed_nxt = 1'b1;
        if (!last_raw_nxt) safe_seen_nxt = 1'b1;
      end else if (!last_raw_nxt) begin
        safe_seen_nxt = 1'b1;
        auth_nxt      = 1'b0;
      end else begin
        auth_nxt = safe_seen_r;
      end
    end

    if (s1_pkt_r) begin
      pkt_seen_nxt = 1'b1;
      pkt_age_nxt  = '0;
    end else if (pkt_seen_r) begin
      pkt_age_nxt = (&pkt_age_r) ? pkt_age_r : pkt_age_r + 1'b1;
    end

    fresh   = pkt_seen_nxt && (CMP_W'(pkt_age_nxt) <= CMP_W'(timeout_r));
    preview = s1_link_r && fresh;
    if (!confirmed_nxt) status = SW_CHECKING;
    else if (stable_nxt) status = SW_ARM;
    else status = SW_SAFE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r  <= 1'b0;
      stable_r    <= 1'b0;
      confirmed_r <= 1'b0;
      safe_seen_r <= 1'b0;
      auth_r      <= 1'b0;
      pkt_seen_r  <= 1'b0;
      level_age_r <= '0;
      pkt_age_r   <= '0;
    end else if (advance) begin
      last_raw_r  <= last_raw_nxt;
      stable_r    <= stable_nxt;
      confirmed_r <= confirmed_nxt;
      safe_seen_r <= safe_seen_nxt;
      auth_r      <= auth_nxt;
      pkt_seen_r  <= pkt_seen_nxt;
      level_age_r <= level_age_nxt;
      pkt_age_r   <= pkt_age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {3'b000, status, auth_nxt && preview, preview, auth_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/aiog_checker.sv =====
// ----------------------------------------------------------------------------
// aiog_checker
// Port-level checks for the arm interlock output gate, bound to the top level.
// ----------------------------------------------------------------------------
module aiog_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [aiog_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import aiog_pkg::*;

  a_stage_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[0] && out_tdata[1])
    else $error("stage enabled without authorization and preview");

  a_auth_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[4:3] == SW_ARM)
    else $error("authorized while switch not stable ARM");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input blocked while result side free");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind arm_interlock_output_gate aiog_checker u_aiog_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tb_arm_interlock_output_gate.sv =====
// ----------------------------------------------------------------------------
// tb_arm_interlock_output_gate
// Self-checking bench for the arm interlock output gate. A table of directed
// ticks and register writes covers reset values, boot in ARM, zero debounce,
// zero timeout, glitch revocation and extreme register values. It is followed
// by random switch runs over several register settings and a short run at
// the extreme register values. Typed table rows are compared against their
// listed result and every other result against an in-bench model of the
// debounce, authorization and packet age logic, under random idling on both
// sides, a long receiver hold-off and a pause that drains the block.
// ----------------------------------------------------------------------------
module tb_arm_interlock_output_gate;
  timeunit 1ns;
  timeprecision 1ps;

  import aiog_pkg::*;

  localparam int GATE_LATENCY = 2;
  localparam int AGE_W        = AGE_WIDTH_DEF;
  localparam int NUM_DIR      = 20;
  localparam int SEG_ITEMS    = 90;

  typedef struct packed {
    logic       auth;
    logic       preview;
    logic       stage;
    sw_status_t status;
  } gate_res_t;

  typedef enum logic {ROW_TICK, ROW_CFG} dir_kind_t;

  typedef struct {
    dir_kind_t      kind;
    cfg_reg_t       reg_sel;
    logic [15:0]    cfg_val;
    logic           sw;
    logic           lnk;
    logic           pkt;
    int unsigned    reps;
    bit             typed;
    gate_res_t      res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_WIDTH-1:0]  cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // model state
  logic [CFG_WIDTH-1:0] dbnc_ticks  = DEBOUNCE_RESET;
  logic [CFG_WIDTH-1:0] pkt_timeout = TIMEOUT_RESET;
  logic                 raw_last    = 1'b0;
  logic                 lvl_stable  = 1'b0;
  logic                 lvl_confirmed = 1'b0;
  logic                 safe_seen_q = 1'b0;
  logic                 auth_q      = 1'b0;
  logic [AGE_W-1:0]     lvl_age     = '0;
  logic [AGE_W-1:0]     pkt_age     = '0;
  logic                 pkt_seen_q  = 1'b0;

  gate_res_t   gate_expected_q[$];
  int unsigned gate_err_cnt  = 0;
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  int unsigned rx_hold_cycles = 0;

  logic [15:0] seg_dbnc [8] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd5, 16'hFFFF, 16'd4, 16'd0};
  logic [15:0] seg_tmo  [8] = '{16'd0, 16'd1, 16'd5, 16'd10, 16'd20, 16'd3, 16'hFFFF, 16'd0};

  //  kind      reg           value     sw    lnk   pkt  reps typed result
  dir_row_t dir_rows [NUM_DIR] = '{
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, 1'b0, 1, 1'b1,
      '{1'b0, 1'b0, 1'b0, SW_CHECKING}},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, 1'b1, 1, 1'b1,
      '{1'b0, 1'b1, 1'b0, SW_CHECKING}},
    '{ROW_CFG,  REG_DEBOUNCE, 16'd2,    1'b0, 1'b0, 1'b0, 1, 1'b0, '0},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, 1'b0, 1, 1'b0, '0},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, 1'b0, 1, 1'b1,
      '{1'b0, 1'b1, 1'b0, SW_ARM}},
    '{ROW_CFG,  REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, 1'b0, 1, 1'b0, '0},
    '{ROW_CFG,  REG_TIMEOUT,  16'd0,    1'b0, 1'b0, 1'b0, 1, 1'b0, '0},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b0, 1'b1, 1'b0, 1, 1'b0, '0},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, 1'b1, 1, 1'b0, '0},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, 1'b0, 2, 1'b0, '0},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, 1'b1, 1, 1'b0, '0},
    '{ROW_CFG,  REG_DEBOUNCE, 16'd3,    1'b0, 1'b0, 1'b0, 1, 1'b0, '0},
    '{ROW_CFG,  REG_TIMEOUT,  16'd4,    1'b0, 1'b0, 1'b0, 1, 1'b0, '0},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b0, 1'b1, 1'b1, 1, 1'b0, '0},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, 1'b0, 4, 1'b0, '0},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b0, 1'b1, 1'b0, 4, 1'b0, '0},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, 1'b1, 4, 1'b0, '0},
    '{ROW_CFG,  REG_DEBOUNCE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1, 1'b0, '0},
    '{ROW_CFG,  REG_TIMEOUT,  16'hFFFF, 1'b0, 1'b0, 1'b0, 1, 1'b0, '0},
    '{ROW_TICK, REG_DEBOUNCE, 16'd0,    1'b0, 1'b1, 1'b0, 3, 1'b0, '0}
  };

  arm_interlock_output_gate i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  task automatic gate_model_tick(input logic sw, input logic lnk, input logic pkt,
                                 output gate_res_t res);
    logic settled;
    logic fresh;
    if (!sw) auth_q = 1'b0;
    if (sw != raw_last) begin
      raw_last = sw;
      lvl_age  = '0;
    end else if (lvl_age != '1) begin
      lvl_age = lvl_age + 1'b1;
    end
    settled = 32'(lvl_age) >= 32'(dbnc_ticks);
    if (settled && (!lvl_confirmed || lvl_stable != raw_last)) begin
      lvl_stable = raw_last;
      if (!lvl_confirmed) begin
        lvl_confirmed = 1'b1;
        if (!lvl_stable) safe_seen_q = 1'b1;
      end else if (!lvl_stable) begin
        safe_seen_q = 1'b1;
        auth_q      = 1'b0;
      end else begin
        auth_q = safe_seen_q;
      end
    end
    if (pkt) begin
      pkt_seen_q = 1'b1;
      pkt_age    = '0;
    end else if (pkt_seen_q && pkt_age != '1) begin
      pkt_age = pkt_age + 1'b1;
    end
    fresh       = pkt_seen_q && (32'(pkt_age) <= 32'(pkt_timeout));
    res.auth    = auth_q;
    res.preview = lnk && fresh;
    res.stage   = auth_q && lnk && fresh;
    res.status  = !lvl_confirmed ? SW_CHECKING : (lvl_stable ? SW_ARM : SW_SAFE);
  endtask

  function automatic void note_failure(input string msg);
    gate_err_cnt++;
    if (gate_err_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  task automatic send_tick(input logic sw, input logic lnk, input logic pkt,
                           input bit typed, input gate_res_t typed_res);
    gate_res_t pred;
    while (tx_idle_en && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, pkt, lnk, sw};
    do @(posedge clk); while (!in_tready);
    gate_model_tick(sw, lnk, pkt, pred);
    gate_expected_q.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (gate_expected_q.size() != 0) @(negedge clk);
    repeat (GATE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t sel, input logic [15:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (sel)
      REG_DEBOUNCE: dbnc_ticks  = val;
      REG_TIMEOUT:  pkt_timeout = val;
      default: ;
    endcase
  endtask

  // random switch runs: mostly runs past the debounce count (capped at 16), some glitches and single-sample noise
  task automatic run_switch_runs(input int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    int unsigned eff;
    int unsigned k;
    logic        lvl;
    logic        sw;
    sent = 0;
    lvl  = 1'($urandom_range(1));
    while (sent < n_items) begin
      lvl = ~lvl;
      eff = (dbnc_ticks > 16) ? 16 : dbnc_ticks;
      if ($urandom_range(9) < 7) run_len = eff + $urandom_range(1, 6);
      else run_len = $urandom_range(1, (eff == 0) ? 1 : eff);
      for (k = 0; k < run_len && sent < n_items; k++) begin
        sw = ($urandom_range(99) < 4) ? ~lvl : lvl;
        send_tick(sw, $urandom_range(99) < 85, $urandom_range(99) < 20, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // receiver: random stalls, or a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_cycles - 1) @(negedge clk);
        rx_hold_cycles = 0;
      end else begin
        out_tready <= rx_idle_en ? ($urandom_range(99) >= 22) : 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    gate_res_t got;
    gate_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.auth    = out_tdata[0];
      got.preview = out_tdata[1];
      got.stage   = out_tdata[2];
      got.status  = sw_status_t'(out_tdata[4:3]);
      if (gate_expected_q.size() == 0) begin
        note_failure($sformatf("result with no request pending: %b", out_tdata));
      end else begin
        want = gate_expected_q.pop_front();
        if (got.auth !== want.auth || got.preview !== want.preview ||
            got.stage !== want.stage || got.status !== want.status)
          note_failure($sformatf(
            "auth exp %b got %b, preview exp %b got %b, stage exp %b got %b, status exp %0d got %0d",
            want.auth, got.auth, want.preview, got.preview, want.stage, got.stage,
            want.status, got.status));
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("arm_interlock_output_gate verification failed");
    $finish;
  end

  initial begin
    int unsigned i;
    int unsigned seg;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_DEBOUNCE;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        cfg_write(dir_rows[i].reg_sel, dir_rows[i].cfg_val);
      end else begin
        repeat (dir_rows[i].reps)
          send_tick(dir_rows[i].sw, dir_rows[i].lnk, dir_rows[i].pkt,
                    dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (seg = 0; seg < 8; seg++) begin
      if (seg == 7) begin
        seg_dbnc[seg] = 16'($urandom_range(1, 8));
        seg_tmo[seg]  = 16'($urandom_range(0, 30));
      end
      cfg_write(REG_DEBOUNCE, seg_dbnc[seg]);
      cfg_write(REG_TIMEOUT, seg_tmo[seg]);
      tx_idle_en = (seg != 4);
      rx_idle_en = (seg != 4);
      // hold the receiver off while requests keep coming
      if (seg == 2) rx_hold_cycles = 300;
      run_switch_runs(SEG_ITEMS / 2);
      // drain the block mid-segment
      if (seg == 5) wait_drained();
      run_switch_runs(SEG_ITEMS / 2);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // run the age counters against the extreme register values
    cfg_write(REG_DEBOUNCE, 16'd1);
    repeat (3) send_tick(1'b1, 1'b1, 1'b0, 1'b0, '0);
    cfg_write(REG_DEBOUNCE, 16'hFFFF);
    cfg_write(REG_TIMEOUT, 16'hFFFE);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0, '0);
    repeat (40) send_tick(1'b0, 1'b1, 1'b0, 1'b0, '0);
    cfg_write(REG_TIMEOUT, 16'hFFFF);
    repeat (4) send_tick(1'b0, 1'b1, 1'b0, 1'b0, '0);

    wait_drained();
    repeat (GATE_LATENCY + 4) @(negedge clk);
    if (gate_err_cnt == 0 && gate_expected_q.size() == 0)
      $display("arm_interlock_output_gate verification clean");
    else
      $display("arm_interlock_output_gate verification failed");
    $finish;
  end

endmodule
